FILE: hw/rtl/pve_pkg.sv
// types, constants and saturation helpers shared by the pose velocity estimator
`default_nettype none

package pve_pkg;

	typedef struct packed {
		logic        [62:0] stamp_ns;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} pve_in_t;

	typedef struct packed {
		logic        [62:0] out_stamp_ns;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [15:0] out_quat_x;
		logic signed [15:0] out_quat_y;
		logic signed [15:0] out_quat_z;
		logic signed [15:0] out_quat_w;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic        [1:0]  fault;
	} pve_out_t;

	localparam logic [1:0] FAULT_OK  = 2'd0;
	localparam logic [1:0] FAULT_DT  = 2'd1;
	localparam logic [1:0] FAULT_YAW = 2'd2;

	localparam logic        REG_IDX_BETA = 1'b0;
	localparam logic [15:0] BETA_RESET   = 16'd13107;

	localparam logic signed [33:0] NS_PER_S = 34'sd1000000000;
	localparam logic signed [65:0] YAW_ONE  = 66'sd134217728;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	// quotient magnitude plus overflow flag and sign back to a saturated value
	function automatic logic signed [31:0] div_sat(input logic [31:0] q, input logic ovf,
		input logic neg);
		if (ovf) begin
			return neg ? 32'sh80000000 : 32'sh7fffffff;
		end else if (!neg) begin
			return q[31] ? 32'sh7fffffff : $signed(q);
		end else begin
			return (q > 32'h80000000) ? 32'sh80000000 : $signed(32'(-q));
		end
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pve_chan_if.sv
// valid/ready channel carrying one transaction payload
`default_nettype none

interface pve_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pose_velocity_estimator.sv
// pose velocity estimator: finite difference velocity, yaw rotation, low-pass filter
// a faulted pose skips the divides, the yaw rotation and the filter update; the multiplies
//   are serial shift-and-add, and the square root and the divides are iterative
// one pose at a time: a new pose is accepted only once the last result is in the
//   output register, where it waits while the next pose is accepted and worked on
// reset: arst_n async, clears pose history and filter, filter_beta back to 13107
`default_nettype none

module pose_velocity_estimator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pve_chan_if.sink         in_ch,
	pve_chan_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import pve_pkg::*;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_SQRT = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	// multiply steps, in program order; the successor is always the next code
	typedef enum logic [3:0] {
		OP_QXY, OP_QWZ, OP_QXX, OP_QZZ, OP_AA, OP_BB,
		OP_D0, OP_D1, OP_D2,
		OP_RXB, OP_RXA, OP_RYB, OP_RYA,
		OP_F0, OP_F1, OP_F2
	} op_t;

	state_t state_q;
	op_t    op_q;

	// config and history
	logic        [15:0] beta_q;
	logic        [62:0] last_stamp_q;
	logic signed [31:0] last_pos_q [3];
	logic signed [31:0] filt_q [3];

	// captured transaction and derived terms
	pve_in_t            in_q;
	logic signed [63:0] dt_q;
	logic signed [32:0] d_q [3];
	logic signed [32:0] a_q;
	logic signed [32:0] b_q;
	logic        [31:0] n_q;
	logic signed [31:0] v_q [3];
	logic signed [31:0] r_q [2];
	logic        [1:0]  fault_q;

	// shift-and-add multiplier, one multiplier bit per cycle
	logic signed [65:0] acc_q;
	logic signed [65:0] mcand_q;
	logic        [33:0] mpl_q;

	// bit-pair square root
	logic [63:0] sq_v_q;
	logic [63:0] sq_r_q;
	logic [63:0] sq_bit_q;

	// restoring divider, one quotient bit per cycle
	logic [63:0] rem_q;
	logic [31:0] quo_q;
	logic [63:0] den_q;
	logic        dneg_q;
	logic        dovf_q;
	logic [4:0]  cnt_q;

	pve_out_t out_q;
	logic     out_valid_q;

	// apb port, single register
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_BETA);
	assign prdata = (paddr[2] == REG_IDX_BETA) ? {16'd0, beta_q} : 32'd0;

	// handshakes
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	logic out_free;
	assign out_free = !out_valid_q || out_ch.ready;

	// operand table for the multiply program
	logic               op_set;
	logic signed [65:0] op_preset;
	logic signed [65:0] op_x;
	logic signed [33:0] op_y;
	logic        [1:0]  fidx;

	always_comb begin
		op_set    = 1'b0;
		op_preset = '0;
		op_x      = '0;
		op_y      = '0;
		fidx      = 2'd0;
		unique case (op_q)
			OP_QXY: begin
				op_set = 1'b1;
				op_x   = 66'($signed(in_q.quat_x));
				op_y   = 34'($signed(in_q.quat_y));
			end
			OP_QWZ: begin
				op_x = 66'($signed(in_q.quat_w));
				op_y = 34'($signed(in_q.quat_z));
			end
			// b starts at one in q27 and the squares are taken off
			OP_QXX: begin
				op_set    = 1'b1;
				op_preset = YAW_ONE;
				op_x      = -66'($signed(in_q.quat_x));
				op_y      = 34'($signed(in_q.quat_x));
			end
			OP_QZZ: begin
				op_x = -66'($signed(in_q.quat_z));
				op_y = 34'($signed(in_q.quat_z));
			end
			OP_AA: begin
				op_set = 1'b1;
				op_x   = 66'(a_q);
				op_y   = 34'(a_q);
			end
			OP_BB: begin
				op_x = 66'(b_q);
				op_y = 34'(b_q);
			end
			OP_D0: begin
				op_set = 1'b1;
				op_x   = 66'(d_q[0]);
				op_y   = NS_PER_S;
			end
			OP_D1: begin
				op_set = 1'b1;
				op_x   = 66'(d_q[1]);
				op_y   = NS_PER_S;
			end
			OP_D2: begin
				op_set = 1'b1;
				op_x   = 66'(d_q[2]);
				op_y   = NS_PER_S;
			end
			OP_RXB: begin
				op_set = 1'b1;
				op_x   = 66'(v_q[0]);
				op_y   = 34'(b_q);
			end
			OP_RXA: begin
				op_x = 66'(v_q[1]);
				op_y = 34'(a_q);
			end
			OP_RYB: begin
				op_set = 1'b1;
				op_x   = 66'(v_q[1]);
				op_y   = 34'(b_q);
			end
			OP_RYA: begin
				op_x = -66'(v_q[0]);
				op_y = 34'(a_q);
			end
			// filter error times beta
			OP_F0: begin
				op_set = 1'b1;
				op_x   = 66'(filt_q[0]) - 66'(r_q[0]);
				op_y   = $signed({18'd0, beta_q});
				fidx   = 2'd0;
			end
			OP_F1: begin
				op_set = 1'b1;
				op_x   = 66'(filt_q[1]) - 66'(r_q[1]);
				op_y   = $signed({18'd0, beta_q});
				fidx   = 2'd1;
			end
			OP_F2: begin
				op_set = 1'b1;
				op_x   = 66'(filt_q[2]) - 66'(v_q[2]);
				op_y   = $signed({18'd0, beta_q});
				fidx   = 2'd2;
			end
		endcase
	end

	logic mul_done;
	assign mul_done = (mpl_q == '0);

	// filter update: step is the product over 2^16 truncated toward zero
	logic signed [65:0] f_step;
	logic signed [65:0] f_sum;
	assign f_step = (acc_q + (acc_q[65] ? 66'sd65535 : 66'sd0)) >>> 16;
	assign f_sum  = 66'(filt_q[fidx]) - f_step;

	// divider launch: sign and magnitude of the accumulator
	logic        dl_neg;
	logic [65:0] dl_mag;
	logic [63:0] dl_den;
	logic        dl_ovf;
	assign dl_neg = acc_q[65];
	assign dl_mag = dl_neg ? 66'(-acc_q) : 66'(acc_q);
	assign dl_den = (op_q == OP_RXA || op_q == OP_RYA) ? {32'd0, n_q} : 64'(dt_q);
	// quotient of at least 2^32 saturates regardless of sign
	assign dl_ovf = ({32'd0, dl_mag[63:32]} >= dl_den);

	// divider iteration
	logic [64:0] dv_sh;
	logic        dv_ge;
	logic [63:0] dv_rem;
	logic [31:0] dv_quo;
	logic signed [31:0] dv_res;
	assign dv_sh  = {rem_q, quo_q[31]};
	assign dv_ge  = (dv_sh >= {1'b0, den_q});
	assign dv_rem = dv_ge ? 64'(dv_sh - {1'b0, den_q}) : dv_sh[63:0];
	assign dv_quo = {quo_q[30:0], dv_ge};
	assign dv_res = div_sat(dv_quo, dovf_q, dneg_q);

	// square root iteration
	logic [63:0] sq_t;
	logic        sq_ge;
	logic [63:0] sq_r_nxt;
	assign sq_t     = sq_r_q + sq_bit_q;
	assign sq_ge    = (sq_v_q >= sq_t);
	assign sq_r_nxt = sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);

	logic dt_bad;
	assign dt_bad = dt_q[63] || (dt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_QXY;
			beta_q        <= BETA_RESET;
			last_stamp_q  <= '0;
			last_pos_q[0] <= '0;
			last_pos_q[1] <= '0;
			last_pos_q[2] <= '0;
			filt_q[0]     <= '0;
			filt_q[1]     <= '0;
			filt_q[2]     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				beta_q <= pwdata[15:0];
			end
			// in ST_DONE the output register is handled below
			if (out_valid_q && out_ch.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						// history moves on with every transaction, fault or not
						in_q          <= in_ch.data;
						dt_q          <= $signed({1'b0, in_ch.data.stamp_ns})
							- $signed({1'b0, last_stamp_q});
						d_q[0]        <= 33'($signed(in_ch.data.pos_x)) - 33'(last_pos_q[0]);
						d_q[1]        <= 33'($signed(in_ch.data.pos_y)) - 33'(last_pos_q[1]);
						d_q[2]        <= 33'($signed(in_ch.data.pos_z)) - 33'(last_pos_q[2]);
						last_stamp_q  <= in_ch.data.stamp_ns;
						last_pos_q[0] <= in_ch.data.pos_x;
						last_pos_q[1] <= in_ch.data.pos_y;
						last_pos_q[2] <= in_ch.data.pos_z;
						op_q          <= OP_QXY;
						state_q       <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (op_set) begin
						acc_q <= op_preset;
					end
					// sign of the multiplier folds into the multiplicand
					mcand_q <= op_y[33] ? -op_x : op_x;
					mpl_q   <= op_y[33] ? 34'(-op_y) : 34'(op_y);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (!mul_done) begin
						acc_q   <= acc_q + (mpl_q[0] ? mcand_q : 66'sd0);
						mcand_q <= mcand_q <<< 1;
						mpl_q   <= mpl_q >> 1;
					end else begin
						unique case (op_q)
							OP_QXY, OP_QXX, OP_AA, OP_RXB, OP_RYB: begin
								op_q    <= op_t'(op_q + 4'd1);
								state_q <= ST_LOAD;
							end
							OP_QWZ: begin
								a_q     <= acc_q[32:0];
								op_q    <= op_t'(op_q + 4'd1);
								state_q <= ST_LOAD;
							end
							OP_QZZ: begin
								b_q     <= acc_q[32:0];
								op_q    <= op_t'(op_q + 4'd1);
								state_q <= ST_LOAD;
							end
							OP_BB: begin
								sq_v_q   <= acc_q[63:0];
								sq_r_q   <= '0;
								sq_bit_q <= 64'd1 << 62;
								cnt_q    <= '0;
								state_q  <= ST_SQRT;
							end
							OP_D0, OP_D1, OP_D2, OP_RXA, OP_RYA: begin
								dneg_q  <= dl_neg;
								dovf_q  <= dl_ovf;
								den_q   <= dl_den;
								rem_q   <= {32'd0, dl_mag[63:32]};
								quo_q   <= dl_mag[31:0];
								cnt_q   <= '0;
								state_q <= ST_DIV;
							end
							OP_F0, OP_F1, OP_F2: begin
								filt_q[fidx] <= sat32(f_sum);
								if (op_q == OP_F2) begin
									state_q <= ST_DONE;
								end else begin
									op_q    <= op_t'(op_q + 4'd1);
									state_q <= ST_LOAD;
								end
							end
						endcase
					end
				end
				ST_SQRT: begin
					if (sq_ge) begin
						sq_v_q <= sq_v_q - sq_t;
					end
					sq_r_q   <= sq_r_nxt;
					sq_bit_q <= sq_bit_q >> 2;
					cnt_q    <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						n_q <= sq_r_nxt[31:0];
						// non-positive time step wins over a degenerate yaw
						priority if (dt_bad) begin
							fault_q <= FAULT_DT;
							state_q <= ST_DONE;
						end else if (sq_r_nxt == '0) begin
							fault_q <= FAULT_YAW;
							state_q <= ST_DONE;
						end else begin
							fault_q <= FAULT_OK;
							op_q    <= OP_D0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DIV: begin
					if (!dovf_q) begin
						rem_q <= dv_rem;
						quo_q <= dv_quo;
					end
					cnt_q <= cnt_q + 5'd1;
					if (dovf_q || cnt_q == 5'd31) begin
						unique case (op_q)
							OP_D0:   v_q[0] <= dv_res;
							OP_D1:   v_q[1] <= dv_res;
							OP_D2:   v_q[2] <= dv_res;
							OP_RXA:  r_q[0] <= dv_res;
							OP_RYA:  r_q[1] <= dv_res;
							default: ;
						endcase
						op_q    <= op_t'(op_q + 4'd1);
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q.out_stamp_ns <= in_q.stamp_ns;
						out_q.out_pos_x    <= in_q.pos_x;
						out_q.out_pos_y    <= in_q.pos_y;
						out_q.out_pos_z    <= in_q.pos_z;
						out_q.out_quat_x   <= in_q.quat_x;
						out_q.out_quat_y   <= in_q.quat_y;
						out_q.out_quat_z   <= in_q.quat_z;
						out_q.out_quat_w   <= in_q.quat_w;
						out_q.vel_x        <= filt_q[0];
						out_q.vel_y        <= filt_q[1];
						out_q.vel_z        <= filt_q[2];
						out_q.fault        <= fault_q;
						out_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a divide only ever starts once the divisor is known to be positive
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> den_q != '0)
		else $error("divider running with zero divisor");

	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT |-> $onehot(sq_bit_q))
		else $error("sqrt bit register lost its single set bit");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> state_q == ST_LOAD && op_q == OP_QXY)
		else $error("transaction accepted without starting the program");

	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.fault == FAULT_OK || out_q.fault == FAULT_DT
			|| out_q.fault == FAULT_YAW))
		else $error("undefined fault code on output");

endmodule

`default_nettype wire
